// ----- src/cdad_pkg.sv -----
`default_nettype none
package cdad_pkg;

  // Field widths of the date.
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YR_W    = 14;
  localparam int DOY_W   = 9;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;
  localparam logic [CFG_IDX_W-1:0] REG_START_DAY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_MONTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_YEAR  = 2'd2;

  // Calendar constants.
  localparam logic [YR_W-1:0]    LEAP_CYCLE     = 14'd400;
  localparam logic [YR_W-1:0]    LEAP_CYCLE_END = 14'd399;
  localparam logic [DOY_W-1:0]   DAYS_COMMON    = 9'd365;
  localparam logic [DOY_W-1:0]   DAYS_LEAP      = 9'd366;
  localparam logic [MONTH_W-1:0] MONTH_JAN      = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB      = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC      = 4'd12;

  // Datapath operations.
  typedef logic [2:0] op_t;
  localparam op_t OP_NOP     = 3'd0;
  localparam op_t OP_LOAD    = 3'd1;
  localparam op_t OP_MOD400  = 3'd2;
  localparam op_t OP_LEAPDAY = 3'd3;
  localparam op_t OP_FIRST   = 3'd4;
  localparam op_t OP_YEAR    = 3'd5;
  localparam op_t OP_MONTH   = 3'd6;
  localparam op_t OP_EMIT    = 3'd7;

  // Jump conditions.
  typedef logic [2:0] cond_t;
  localparam cond_t COND_NEVER      = 3'd0;
  localparam cond_t COND_ALWAYS     = 3'd1;
  localparam cond_t COND_GE400      = 3'd2;
  localparam cond_t COND_FITS       = 3'd3;
  localparam cond_t COND_OVER_YEAR  = 3'd4;
  localparam cond_t COND_MORE_MONTH = 3'd5;

  // Program addresses.
  typedef logic [2:0] pc_t;
  localparam pc_t PC_LOAD    = 3'd0;
  localparam pc_t PC_MOD400  = 3'd1;
  localparam pc_t PC_LEAPDAY = 3'd2;
  localparam pc_t PC_FIRST   = 3'd3;
  localparam pc_t PC_YEAR    = 3'd4;
  localparam pc_t PC_MONTH   = 3'd5;
  localparam pc_t PC_EMIT    = 3'd6;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
    logic  last;
  } uword_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    op_t op;
  } ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic ge400;
    logic fits;
    logic over_year;
    logic more_month;
  } status_t;

  // Microcode program. Each loop step jumps to itself while its condition holds.
  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    unique case (pc)
      PC_LOAD:    w = '{op: OP_LOAD,    cond: COND_NEVER,      target: PC_LOAD,   last: 1'b0};
      PC_MOD400:  w = '{op: OP_MOD400,  cond: COND_GE400,      target: PC_MOD400, last: 1'b0};
      PC_LEAPDAY: w = '{op: OP_LEAPDAY, cond: COND_NEVER,      target: PC_LOAD,   last: 1'b0};
      PC_FIRST:   w = '{op: OP_FIRST,   cond: COND_FITS,       target: PC_MONTH,  last: 1'b0};
      PC_YEAR:    w = '{op: OP_YEAR,    cond: COND_OVER_YEAR,  target: PC_YEAR,   last: 1'b0};
      PC_MONTH:   w = '{op: OP_MONTH,   cond: COND_MORE_MONTH, target: PC_MONTH,  last: 1'b0};
      PC_EMIT:    w = '{op: OP_EMIT,    cond: COND_NEVER,      target: PC_LOAD,   last: 1'b1};
      default:    w = '{op: OP_NOP,     cond: COND_NEVER,      target: PC_LOAD,   last: 1'b1};
    endcase
    return w;
  endfunction

  // Days in the months before the given one; invalid months count none.
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] d;
    unique case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Length of a month, February by the leap flag.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] d;
    unique case (m)
      4'd2:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  // Leap test on a year already reduced modulo 400.
  function automatic logic is_leap(input logic [YR_W-1:0] m400);
    return (m400[1:0] == 2'd0) && (m400 != 14'd100) && (m400 != 14'd200)
           && (m400 != 14'd300);
  endfunction

endpackage
`default_nettype wire

// ----- src/cdad_seq.sv -----
`default_nettype none
module cdad_seq (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  input  wire cdad_pkg::status_t  status,
  output cdad_pkg::ctrl_t         ctrl,
  output logic                    busy
);
  import cdad_pkg::*;

  pc_t    pc_r, pc_nxt;
  logic   busy_r, busy_nxt;
  uword_t word;
  logic   take;

  // Fetch the current control word.
  assign word = ucode_rom(pc_r);

  // Condition select for the jump.
  always_comb begin
    unique case (word.cond)
      COND_NEVER:      take = 1'b0;
      COND_ALWAYS:     take = 1'b1;
      COND_GE400:      take = status.ge400;
      COND_FITS:       take = status.fits;
      COND_OVER_YEAR:  take = status.over_year;
      COND_MORE_MONTH: take = status.more_month;
      default:         take = 1'b0;
    endcase
  end

  // Step counter and run flag. The load step runs in the cycle a beat is taken.
  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    ctrl.op  = OP_NOP;
    if (busy_r) begin
      ctrl.op = word.op;
      if (word.last) begin
        busy_nxt = 1'b0;
        pc_nxt   = PC_LOAD;
      end else if (take) begin
        pc_nxt = word.target;
      end else begin
        pc_nxt = pc_r + 3'd1;
      end
    end else if (start) begin
      ctrl.op  = OP_LOAD;
      busy_nxt = 1'b1;
      pc_nxt   = PC_MOD400;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= PC_LOAD;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule
`default_nettype wire

// ----- src/cdad_datapath.sv -----
`default_nettype none
module cdad_datapath #(
  parameter int DAYS_WIDTH = 20
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire cdad_pkg::ctrl_t           ctrl,
  input  wire [DAYS_WIDTH-1:0]           in_days_to_add,
  input  wire [cdad_pkg::DAY_W-1:0]      start_day,
  input  wire [cdad_pkg::MONTH_W-1:0]    start_month,
  input  wire [cdad_pkg::YR_W-1:0]       start_year,
  output cdad_pkg::status_t              status,
  output logic                           out_valid,
  output logic [cdad_pkg::DAY_W-1:0]     out_new_day,
  output logic [cdad_pkg::MONTH_W-1:0]   out_new_month,
  output logic [cdad_pkg::YR_W-1:0]      out_new_year
);
  import cdad_pkg::*;

  // The day count must also hold a day of the year; the year count runs at
  // full precision, while its leap phase is kept by the separate modulo-400 count.
  localparam int CNT_W   = (DAYS_WIDTH > DOY_W) ? DAYS_WIDTH : DOY_W;
  localparam int YHI_W   = ((DAYS_WIDTH - 8) > YR_W) ? (DAYS_WIDTH - 8) : YR_W;
  localparam int YFULL_W = YHI_W + 2;

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [YFULL_W-1:0] year_r, year_nxt;
  logic [YR_W-1:0]    m400_r, m400_nxt;
  logic [DOY_W-1:0]   doy_r, doy_nxt;
  logic [MONTH_W-1:0] month_r, month_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DAY_W-1:0]   day_out_r, day_out_nxt;
  logic [MONTH_W-1:0] month_out_r, month_out_nxt;
  logic [YR_W-1:0]    year_out_r, year_out_nxt;

  logic               leap;
  logic [DOY_W-1:0]   ylen;
  logic [DOY_W-1:0]   rem;
  logic [DAY_W-1:0]   mlen;
  logic [YR_W-1:0]    m400_inc;

  // Year and month lengths of the year being walked.
  assign leap     = is_leap(m400_r);
  assign ylen     = leap ? DAYS_LEAP : DAYS_COMMON;
  assign rem      = ylen - doy_r;
  assign mlen     = month_len(month_r, leap);
  assign m400_inc = (m400_r == LEAP_CYCLE_END) ? '0 : m400_r + 14'd1;

  // Status for the sequencer's jumps.
  assign status.ge400      = (m400_r >= LEAP_CYCLE);
  assign status.fits       = (cnt_r <= CNT_W'(rem));
  assign status.over_year  = (cnt_r > CNT_W'(ylen));
  assign status.more_month = (cnt_r > CNT_W'(mlen)) && (month_r != MONTH_DEC);

  // Operations selected by the control word.
  always_comb begin
    cnt_nxt       = cnt_r;
    year_nxt      = year_r;
    m400_nxt      = m400_r;
    doy_nxt       = doy_r;
    month_nxt     = month_r;
    out_valid_nxt = 1'b0;
    day_out_nxt   = day_out_r;
    month_out_nxt = month_out_r;
    year_out_nxt  = year_out_r;
    unique case (ctrl.op)
      OP_NOP: begin
      end
      OP_LOAD: begin
        cnt_nxt   = CNT_W'(in_days_to_add);
        year_nxt  = YFULL_W'(start_year);
        m400_nxt  = start_year;
        doy_nxt   = DOY_W'(start_day) + days_before(start_month);
        month_nxt = MONTH_JAN;
      end
      OP_MOD400: begin
        if (status.ge400) begin
          m400_nxt = m400_r - LEAP_CYCLE;
        end
      end
      OP_LEAPDAY: begin
        if (leap && (start_month > MONTH_FEB)) begin
          doy_nxt = doy_r + 9'd1;
        end
      end
      OP_FIRST: begin
        // Either the count stays in the start year or it runs to its end.
        if (status.fits) begin
          cnt_nxt = cnt_r + CNT_W'(doy_r);
        end else begin
          cnt_nxt  = cnt_r - CNT_W'(rem);
          year_nxt = year_r + YFULL_W'(1);
          m400_nxt = m400_inc;
        end
      end
      OP_YEAR: begin
        if (status.over_year) begin
          cnt_nxt  = cnt_r - CNT_W'(ylen);
          year_nxt = year_r + YFULL_W'(1);
          m400_nxt = m400_inc;
        end
      end
      OP_MONTH: begin
        // December absorbs any leftover without moving on.
        if (cnt_r > CNT_W'(mlen)) begin
          cnt_nxt = cnt_r - CNT_W'(mlen);
          if (month_r != MONTH_DEC) begin
            month_nxt = month_r + 4'd1;
          end
        end
      end
      OP_EMIT: begin
        out_valid_nxt = 1'b1;
        day_out_nxt   = cnt_r[DAY_W-1:0];
        month_out_nxt = month_r;
        year_out_nxt  = year_r[YR_W-1:0];
      end
    endcase
  end

  // Working registers and result register.
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    year_r      <= year_nxt;
    m400_r      <= m400_nxt;
    doy_r       <= doy_nxt;
    month_r     <= month_nxt;
    day_out_r   <= day_out_nxt;
    month_out_r <= month_out_nxt;
    year_out_r  <= year_out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_day   = day_out_r;
  assign out_new_month = month_out_r;
  assign out_new_year  = year_out_r;

endmodule
`default_nettype wire

// ----- src/calendar_date_add_days.sv -----
`default_nettype none
// Gregorian date adder. The start date sits in three registers written over the
// cfg_ port (index 0 day, 1 month, 2 year); each beat on start adds
// in_days_to_add days to it and gives one result beat on out_valid, a one-cycle
// strobe that the receiver cannot stall. busy is high after the accepted beat
// until the cycle before the strobe, and a new beat may start in the strobe
// cycle. A small microcode sequencer runs the work on one shared datapath: it
// reduces the start year modulo 400, walks the whole years after the start year
// and then the months up to the one reached (1 to 12), and emits the result.
module calendar_date_add_days #(
  parameter int DAYS_WIDTH = 20
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire [DAYS_WIDTH-1:0]             in_days_to_add,
  output logic                             out_valid,
  output logic [cdad_pkg::DAY_W-1:0]       out_new_day,
  output logic [cdad_pkg::MONTH_W-1:0]     out_new_month,
  output logic [cdad_pkg::YR_W-1:0]        out_new_year,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [cdad_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [cdad_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cdad_pkg::*;

  logic [DAY_W-1:0]   start_day_r, start_day_nxt;
  logic [MONTH_W-1:0] start_month_r, start_month_nxt;
  logic [YR_W-1:0]    start_year_r, start_year_nxt;
  ctrl_t              ctrl;
  status_t            status;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_comb begin
    start_day_nxt   = start_day_r;
    start_month_nxt = start_month_r;
    start_year_nxt  = start_year_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_START_DAY:   start_day_nxt   = cfg_data[DAY_W-1:0];
        REG_START_MONTH: start_month_nxt = cfg_data[MONTH_W-1:0];
        REG_START_YEAR:  start_year_nxt  = cfg_data[YR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_day_r   <= 5'd1;
      start_month_r <= 4'd1;
      start_year_r  <= 14'd2000;
    end else begin
      start_day_r   <= start_day_nxt;
      start_month_r <= start_month_nxt;
      start_year_r  <= start_year_nxt;
    end
  end

  // Sequencer with the microcode program.
  cdad_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  // Shared datapath and result register.
  cdad_datapath #(
    .DAYS_WIDTH (DAYS_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .in_days_to_add (in_days_to_add),
    .start_day      (start_day_r),
    .start_month    (start_month_r),
    .start_year     (start_year_r),
    .status         (status),
    .out_valid      (out_valid),
    .out_new_day    (out_new_day),
    .out_new_month  (out_new_month),
    .out_new_year   (out_new_year)
  );

endmodule
`default_nettype wire
